// ===== hdl/ecc_pkg.sv =====
// Package for the epoch to civil time converter.
// Holds the request and result types, constants and calendar helpers; no dependencies.
package ecc_pkg;
	localparam logic [31:0] SEC_LOW  = 32'd946684800;
	localparam logic [31:0] SEC_HIGH = 32'd4102444799;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [16:0] SEC_PER_HOUR = 17'd3600;

	typedef struct packed {
		logic [11:0] cal_year;
		logic [3:0]  cal_month;
		logic [4:0]  cal_day;
		logic [4:0]  cal_hour;
		logic [5:0]  cal_minute;
		logic [5:0]  cal_second;
		logic [2:0]  week_day;
		logic        summer_time;
		logic        is_local;
	} result_t;

	typedef struct packed {
		logic [31:0] utc_seconds;
	} request_t;

	// Remainder by seven through a reciprocal multiply, exact for any 16-bit value.
	function automatic logic [2:0] mod7(input logic [15:0] x);
		logic [32:0] p;
		logic [15:0] q;
		begin
			p = 33'(x) * 33'd74899;
			q = 16'(p >> 19);
			mod7 = 3'(x - q * 16'd7);
		end
	endfunction

	// Days since 2000-01-01 of the last Sunday of March (or October).
	// Year offset yo is 0..99; 2000-01-01 is a Saturday.
	// Both months follow February, so the leap day of year yo itself is counted.
	function automatic logic [15:0] last_sunday(input logic [6:0] yo, input logic oct);
		logic [15:0] d31;
		logic [15:0] leaps;
		logic [2:0]  wd;
		begin
			leaps = 16'((yo + 7'd4) >> 2);
			d31 = 16'(16'(yo) * 16'd365) + leaps + (oct ? 16'd303 : 16'd89);
			wd = mod7(d31 + 16'd6);
			last_sunday = d31 - 16'(wd);
		end
	endfunction
endpackage

// ===== hdl/ecc_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing but its type parameter.
interface ecc_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ecc_split.sv =====
// Breaks a day count since 2000-01-01 and a time of day into date, time and weekday.
// Three register stages; uses ecc_pkg.
module ecc_split (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] days,
	input  logic [16:0] tod,
	input  logic        summer,
	input  logic        loc,
	output ecc_pkg::result_t res
);
	logic [15:0] days_s1;
	logic [16:0] tod_s1;
	logic [6:0]  yo_s1;
	logic [4:0]  hr_s1;
	logic [2:0]  wd_s1;
	logic        sum_s1, loc_s1;
	logic [6:0]  yo_s2;
	logic [8:0]  doy_s2;
	logic        leap_s2;
	logic [11:0] rem_s2;
	logic [4:0]  hr_s2;
	logic [2:0]  wd_s2;
	logic        sum_s2, loc_s2;
	logic [33:0] yo_prod;
	logic [26:0] hr_prod;
	logic [15:0] ystart;
	logic [20:0] mi_prod;
	logic [5:0]  mi_c;
	logic [3:0]  mon_c;
	logic [4:0]  day_c;

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		begin
			unique case (m)
				4'd2: base = 9'd31;
				4'd3: base = 9'd59;
				4'd4: base = 9'd90;
				4'd5: base = 9'd120;
				4'd6: base = 9'd151;
				4'd7: base = 9'd181;
				4'd8: base = 9'd212;
				4'd9: base = 9'd243;
				4'd10: base = 9'd273;
				4'd11: base = 9'd304;
				4'd12: base = 9'd334;
				default: base = 9'd0;
			endcase
			month_start = base + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
		end
	endfunction

	always_comb begin
		yo_prod = 34'(days) * 34'd367469;
		hr_prod = 27'(tod[16:4]) * 27'd9321;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s1 <= days;
			tod_s1  <= tod;
			yo_s1   <= yo_prod[33:27];
			hr_s1   <= hr_prod[25:21];
			wd_s1   <= ecc_pkg::mod7(days + 16'd6);
			sum_s1  <= summer;
			loc_s1  <= loc;
		end
	end

	always_comb begin
		ystart = 16'(yo_s1) * 16'd365 + 16'((yo_s1 + 7'd3) >> 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yo_s2   <= yo_s1;
			doy_s2  <= 9'(days_s1 - ystart);
			leap_s2 <= (yo_s1[1:0] == 2'd0) && (yo_s1 != 7'd100);
			rem_s2  <= 12'(tod_s1 - 17'(hr_s1) * ecc_pkg::SEC_PER_HOUR);
			hr_s2   <= hr_s1;
			wd_s2   <= wd_s1;
			sum_s2  <= sum_s1;
			loc_s2  <= loc_s1;
		end
	end

	always_comb begin
		mon_c = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (doy_s2 >= month_start(4'(i), leap_s2))
				mon_c = 4'(i);
		end
		day_c = 5'(doy_s2 - month_start(mon_c, leap_s2) + 9'd1);
		mi_prod = 21'(rem_s2[11:2]) * 21'd1093;
		mi_c = mi_prod[19:14];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.cal_year    <= 12'd2000 + 12'(yo_s2);
			res.cal_month   <= mon_c;
			res.cal_day     <= day_c;
			res.cal_hour    <= hr_s2;
			res.cal_minute  <= mi_c;
			res.cal_second  <= 6'(rem_s2 - 12'(mi_c) * 12'd60);
			res.week_day    <= wd_s2;
			res.summer_time <= sum_s2;
			res.is_local    <= loc_s2;
		end
	end
endmodule

// ===== hdl/epoch_to_civil_time_with_cest_core.sv =====
// Top level: UTC seconds to UTC and central European civil time.
// The UTC result of a request is presented first;
// the local result follows it, and a stalled result freezes the pipeline.
// Stage four sends two passes, so no new request is taken during its UTC pass.
// Reset clears the valid bits of the pipeline and the phase flag; no clearing pass.
// Uses ecc_pkg, ecc_if and ecc_split.
module epoch_to_civil_time_with_cest_core (
	input  logic clk,
	input  logic arst_n,
	ecc_if.sink   req,
	ecc_if.source rsp
);
	logic        en;
	logic        hold;
	logic        adv;
	logic        phase_q;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [31:0] sec_s1, sec_s2;
	logic [15:0] day_s2, day_s3, day_s4;
	logic [16:0] tod_s3, tod_s4;
	logic [6:0]  yo_s3;
	logic [15:0] mar_s4, oct_s4;
	logic [31:0] clamp;
	logic [50:0] day_prod;
	logic [33:0] yo_prod;
	logic        summer;
	logic [16:0] ltod, sel_tod;
	logic [15:0] lday, sel_day;
	ecc_pkg::result_t res;

	assign en = !v_s7 || rsp.ready;
	assign hold = v_s4 && !phase_q;
	assign adv = en && !hold;
	assign req.ready = adv;

	always_comb begin
		clamp = req.data.utc_seconds;
		if (clamp < ecc_pkg::SEC_LOW) clamp = ecc_pkg::SEC_LOW;
		if (clamp > ecc_pkg::SEC_HIGH) clamp = ecc_pkg::SEC_HIGH;
		clamp = clamp - ecc_pkg::SEC_LOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			if (en) begin
				phase_q <= hold;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				v_s7 <= v_s6;
			end
			if (adv) begin
				v_s1 <= req.valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_comb begin
		day_prod = 51'(sec_s1[31:7]) * 51'd50903317;
		yo_prod  = 34'(day_s2) * 34'd367469;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s1 <= clamp;
			sec_s2 <= sec_s1;
			day_s2 <= day_prod[50:35];
			day_s3 <= day_s2;
			tod_s3 <= 17'(sec_s2 - 32'(day_s2) * 32'(ecc_pkg::SEC_PER_DAY));
			yo_s3  <= yo_prod[33:27];
			day_s4 <= day_s3;
			tod_s4 <= tod_s3;
			mar_s4 <= ecc_pkg::last_sunday(yo_s3, 1'b0);
			oct_s4 <= ecc_pkg::last_sunday(yo_s3, 1'b1);
		end
	end

	always_comb begin
		summer = ((day_s4 > mar_s4) ||
		          (day_s4 == mar_s4 && tod_s4 >= ecc_pkg::SEC_PER_HOUR)) &&
		         ((day_s4 < oct_s4) ||
		          (day_s4 == oct_s4 && tod_s4 < ecc_pkg::SEC_PER_HOUR));
		ltod = tod_s4 + (summer ? 17'd7200 : ecc_pkg::SEC_PER_HOUR);
		lday = day_s4;
		if (ltod >= ecc_pkg::SEC_PER_DAY) begin
			ltod = ltod - ecc_pkg::SEC_PER_DAY;
			lday = day_s4 + 16'd1;
		end
		sel_day = phase_q ? lday : day_s4;
		sel_tod = phase_q ? ltod : tod_s4;
	end

	ecc_split u_split (
		.clk(clk), .en(en),
		.days(sel_day), .tod(sel_tod), .summer(summer), .loc(phase_q), .res(res)
	);

	assign rsp.valid = v_s7;
	assign rsp.data  = res;

	a_local_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !rsp.data.is_local |=> rsp.valid && rsp.data.is_local)
		else $error("local result missing");
	a_hold_blocks_take: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !phase_q |-> !req.ready) else $error("request taken during UTC pass");
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while stalled");
endmodule

// ===== tb/epoch_to_civil_time_with_cest_core_tb.sv =====
// Testbench for the epoch to civil time converter with summer time.
// Drives UTC second counts, predicts both UTC and local breakdowns and checks them.
// Depends on ecc_pkg, ecc_if and the top level epoch_to_civil_time_with_cest_core.
module epoch_to_civil_time_with_cest_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	ecc_if #(.payload_t(ecc_pkg::request_t)) req (clk);
	ecc_if #(.payload_t(ecc_pkg::result_t))  rsp (clk);

	epoch_to_civil_time_with_cest_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	ecc_pkg::result_t expected_times[$];
	int mismatches = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int summer_seen = 0;

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
	end

	function automatic void split_days(input longint unsigned days, output int yr,
			output int mo, output int dy);
		longint unsigned z, era, doe, yoe, doy, mp;
		z = days + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		mo = (mp < 10) ? int'(mp + 3) : int'(mp - 9);
		dy = int'(doy - (153 * mp + 2) / 5 + 1);
		yr = int'(yoe + era * 400) + ((mo <= 2) ? 1 : 0);
	endfunction

	function automatic longint unsigned days_since_epoch(input int yr, input int mo,
			input int dy);
		longint unsigned y, era, yoe, ms, doy, doe;
		y = yr - ((mo <= 2) ? 1 : 0);
		era = y / 400;
		yoe = y - era * 400;
		ms = (mo > 2) ? mo - 3 : mo + 9;
		doy = (153 * ms + 2) / 5 + dy - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic longint unsigned dst_switch(input int yr, input int mo);
		longint unsigned last;
		last = days_since_epoch(yr, mo, 31);
		return (last - (last + 4) % 7) * 86400 + 3600;
	endfunction

	function automatic ecc_pkg::result_t breakdown(input longint unsigned secs,
			input logic summer, input logic loc);
		ecc_pkg::result_t r;
		longint unsigned days, tod;
		int yr, mo, dy;
		days = secs / 86400;
		tod = secs % 86400;
		split_days(days, yr, mo, dy);
		r.cal_year = 12'(yr);
		r.cal_month = 4'(mo);
		r.cal_day = 5'(dy);
		r.cal_hour = 5'(tod / 3600);
		r.cal_minute = 6'((tod % 3600) / 60);
		r.cal_second = 6'(tod % 60);
		r.week_day = 3'((days + 4) % 7);
		r.summer_time = summer;
		r.is_local = loc;
		return r;
	endfunction

	task automatic predict_civil_times(input logic [31:0] utc);
		longint unsigned s;
		int yr, mo, dy;
		logic summer;
		s = utc;
		if (s < ecc_pkg::SEC_LOW)
			s = ecc_pkg::SEC_LOW;
		if (s > ecc_pkg::SEC_HIGH)
			s = ecc_pkg::SEC_HIGH;
		split_days(s / 86400, yr, mo, dy);
		summer = (s >= dst_switch(yr, 3)) && (s < dst_switch(yr, 10));
		if (summer)
			summer_seen++;
		expected_times.push_back(breakdown(s, summer, 1'b0));
		expected_times.push_back(breakdown(s + (summer ? 7200 : 3600), summer, 1'b1));
	endtask

	task automatic send_seconds(input logic [31:0] utc);
		int idle;
		idle = $urandom_range(0, 4);
		if (idle != 0) begin
			req.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data.utc_seconds <= utc;
		predict_civil_times(utc);
		do @(posedge clk); while (!req.ready);
		requests_sent++;
	endtask

	// Idle gaps are drawn per result, with extra weight on no gap.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		ecc_pkg::result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (expected_times.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp.data);
			end else begin
				want = expected_times.pop_front();
				if (rsp.data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, rsp.data);
				end
			end
		end
	end

	task automatic test_range_edges();
		send_seconds(32'd0);
		send_seconds(32'hFFFF_FFFF);
		send_seconds(ecc_pkg::SEC_LOW - 1);
		send_seconds(ecc_pkg::SEC_LOW);
		send_seconds(ecc_pkg::SEC_HIGH);
		send_seconds(ecc_pkg::SEC_HIGH + 1);
		send_seconds(32'h5555_5555);
		send_seconds(32'hAAAA_AAAA);
		send_seconds(32'd4102441200);
		send_seconds(32'd4102444000);
	endtask

	task automatic test_summer_edges();
		int yr;
		longint unsigned on, off;
		for (int i = 0; i < 4; i++) begin
			yr = (i == 3) ? 2099 : $urandom_range(2000, 2098);
			on = dst_switch(yr, 3);
			off = dst_switch(yr, 10);
			send_seconds(32'(on - 1));
			send_seconds(32'(on));
			send_seconds(32'(off - 1));
			send_seconds(32'(off));
		end
	endtask

	task automatic test_random_seconds();
		int yr;
		for (int i = 0; i < 480; i++) begin
			case ($urandom_range(0, 9))
				0: send_seconds($urandom());
				1, 2: begin
					yr = $urandom_range(2000, 2099);
					send_seconds(32'(dst_switch(yr, ($urandom_range(0, 1)) ? 3 : 10)
						+ $urandom_range(0, 7200) - 3600));
				end
				3: send_seconds(32'(ecc_pkg::SEC_HIGH - $urandom_range(0, 7200)));
				default: send_seconds($urandom_range(ecc_pkg::SEC_HIGH, ecc_pkg::SEC_LOW));
			endcase
		end
	endtask

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_range_edges();
		test_summer_edges();
		test_random_seconds();
		req.valid <= 1'b0;
		waited = 0;
		while (expected_times.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d requests, checked %0d results, %0d in summer time.",
			requests_sent, results_seen, summer_seen);
		if (mismatches == 0 && expected_times.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#200000;
		$display("status: fail");
		$finish;
	end
endmodule
